@@ rtl/inode_slot_refcount_table_macros.svh @@
// Assertion macros for the inode slot reference count table.
`ifndef INODE_SLOT_REFCOUNT_TABLE_MACROS_SVH
`define INODE_SLOT_REFCOUNT_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define ISRT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("isrt assertion failed");
// Next-cycle implication, checked outside reset.
`define ISRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("isrt assertion failed");
`else
`define ISRT_ASSERT_IMPL(lbl, ante, cons)
`define ISRT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/isrt_pkg.sv @@
// Shared types and constants of the inode slot reference count table.
package isrt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic load;    // capture an accepted item
        logic search;  // tag compare / free search cycle
        logic update;  // slot write and result cycle
    } t_cmd;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_FREE_PUT = 2'd2;
    localparam logic [1:0] STAT_ZERO_INO = 2'd3;

    localparam int OFFSET_W    = 3;  // 8 inodes per disk block
    localparam int SLOT_IDX_W  = 6;
    localparam int INO_W       = 32;
    localparam int DEV_W       = 8;
    localparam int REFS_W      = 16;

endpackage

@@ rtl/isrt_ctrl.sv @@
// Sequencer of the inode slot table: accept, search, update.
module isrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output isrt_pkg::t_cmd o_cmd,
    output logic          o_strobe
);
    import isrt_pkg::*;

    t_state r_state, n_state;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_UPDATE);
        end
    end

    always_comb begin
        n_state       = r_state;
        o_busy        = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                o_busy       = 1'b1;
                o_cmd.search = 1'b1;
                n_state      = ST_UPDATE;
            end
            ST_UPDATE: begin
                // slot write lands on this edge, so the next item may load now
                o_cmd.update = 1'b1;
                o_cmd.load   = i_start;
                n_state      = i_start ? ST_SEARCH : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_strobe = r_strobe;

endmodule

@@ rtl/isrt_dp.sv @@
// Datapath: slot registers, tag compare, free search, count update, result registers.
module isrt_dp #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  isrt_pkg::t_cmd                    i_cmd,
    input  logic                              i_cfg_wr_en,
    input  logic [isrt_pkg::INO_W-1:0]        i_cfg_wr_data,
    input  logic                              i_operation,
    input  logic [isrt_pkg::INO_W-1:0]        i_inode_number,
    input  logic [isrt_pkg::DEV_W-1:0]        i_device_id,
    input  logic [isrt_pkg::SLOT_IDX_W-1:0]   i_slot_index,
    input  logic                              i_modified,
    output logic [isrt_pkg::SLOT_IDX_W-1:0]   o_result_slot,
    output logic [1:0]                        o_status,
    output logic                              o_hit,
    output logic                              o_load_request,
    output logic                              o_writeback_request,
    output logic [isrt_pkg::INO_W-1:0]        o_disk_block,
    output logic [isrt_pkg::OFFSET_W-1:0]     o_inode_offset,
    output logic [isrt_pkg::DEV_W-1:0]        o_slot_device,
    output logic [isrt_pkg::REFS_W-1:0]       o_ref_count
);
    import isrt_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // slot store
    logic [INO_W-1:0]  r_slot_ino   [SLOT_COUNT];
    logic [DEV_W-1:0]  r_slot_dev   [SLOT_COUNT];
    logic [REFS_W-1:0] r_slot_refs  [SLOT_COUNT];
    logic              r_slot_dirty [SLOT_COUNT];

    logic [INO_W-1:0]  r_start_blk;

    // captured item
    logic                  r_op;
    logic [INO_W-1:0]      r_ino;
    logic [DEV_W-1:0]      r_dev;
    logic [SLOT_IDX_W-1:0] r_sidx;
    logic                  r_mod;

    // search results
    logic              r_hit_found, r_free_found, r_p_inr, r_p_dirty, r_ino_zero;
    logic [IW-1:0]     r_hit_idx, r_free_idx;
    logic [INO_W-1:0]  r_gpos, r_p_pos;
    logic [DEV_W-1:0]  r_p_dev;
    logic [REFS_W-1:0] r_p_refs;

    logic              hit_found, free_found, put_inr;
    logic [IW-1:0]     hit_idx, free_idx, put_idx;

    // result registers
    logic [SLOT_IDX_W-1:0] r_res_slot;
    logic [1:0]            r_res_status;
    logic                  r_res_hit, r_res_load, r_res_wb;
    logic [INO_W-1:0]      r_res_blk;
    logic [OFFSET_W-1:0]   r_res_off;
    logic [DEV_W-1:0]      r_res_dev;
    logic [REFS_W-1:0]     r_res_refs;

    logic [SLOT_IDX_W-1:0] n_res_slot;
    logic [1:0]            n_res_status;
    logic                  n_res_hit, n_res_load, n_res_wb;
    logic [INO_W-1:0]      n_res_blk;
    logic [OFFSET_W-1:0]   n_res_off;
    logic [DEV_W-1:0]      n_res_dev;
    logic [REFS_W-1:0]     n_res_refs;

    // slot write controls
    logic              wr_claim, wr_refs_en, wr_dirty_en, wr_dirty;
    logic [IW-1:0]     wr_idx;
    logic [REFS_W-1:0] wr_refs;

    logic [REFS_W-1:0] hit_refs, put_refs;
    logic              put_dirty;

    // ---------------- capture and config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_blk <= '0;
        end else if (i_cfg_wr_en) begin
            r_start_blk <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_ino  <= i_inode_number;
            r_dev  <= i_device_id;
            r_sidx <= i_slot_index;
            r_mod  <= i_modified;
        end
    end

    // ---------------- search cycle ----------------
    always_comb begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        // descending scan leaves the lowest matching slot
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_slot_ino[i] != '0 && r_slot_ino[i] == r_ino) begin
                hit_found = 1'b1;
                hit_idx   = IW'(i);
            end
            if (r_slot_refs[i] == '0) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign put_inr = (32'(r_sidx) < 32'(SLOT_COUNT));
    assign put_idx = IW'(r_sidx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_hit_found  <= hit_found;
            r_hit_idx    <= hit_idx;
            r_free_found <= free_found;
            r_free_idx   <= free_idx;
            r_ino_zero   <= (r_ino == '0);
            r_gpos       <= r_ino - INO_W'(1);
            r_p_inr      <= put_inr;
            r_p_pos      <= r_slot_ino[put_idx] - INO_W'(1);
            r_p_dev      <= r_slot_dev[put_idx];
            r_p_refs     <= r_slot_refs[put_idx];
            r_p_dirty    <= r_slot_dirty[put_idx];
        end
    end

    // ---------------- update cycle ----------------
    assign hit_refs  = (r_slot_refs[r_hit_idx] == '1) ? r_slot_refs[r_hit_idx]
                                                       : r_slot_refs[r_hit_idx] + REFS_W'(1);
    assign put_refs  = r_p_refs - REFS_W'(1);
    assign put_dirty = r_p_dirty | r_mod;

    always_comb begin
        n_res_slot   = '0;
        n_res_status = STAT_OK;
        n_res_hit    = 1'b0;
        n_res_load   = 1'b0;
        n_res_wb     = 1'b0;
        n_res_blk    = '0;
        n_res_off    = '0;
        n_res_dev    = '0;
        n_res_refs   = '0;
        wr_claim     = 1'b0;
        wr_refs_en   = 1'b0;
        wr_dirty_en  = 1'b0;
        wr_dirty     = 1'b0;
        wr_idx       = '0;
        wr_refs      = '0;
        if (r_op == OP_GET) begin
            priority if (r_ino_zero) begin
                n_res_status = STAT_ZERO_INO;
            end else if (r_hit_found) begin
                n_res_slot = SLOT_IDX_W'(r_hit_idx);
                n_res_hit  = 1'b1;
                n_res_dev  = r_slot_dev[r_hit_idx];
                n_res_refs = hit_refs;
                wr_idx     = r_hit_idx;
                wr_refs_en = 1'b1;
                wr_refs    = hit_refs;
            end else if (r_free_found) begin
                n_res_slot  = SLOT_IDX_W'(r_free_idx);
                n_res_load  = 1'b1;
                n_res_blk   = (r_gpos >> OFFSET_W) + r_start_blk;
                n_res_off   = r_gpos[OFFSET_W-1:0];
                n_res_dev   = r_dev;
                n_res_refs  = REFS_W'(1);
                wr_idx      = r_free_idx;
                wr_claim    = 1'b1;
                wr_refs_en  = 1'b1;
                wr_refs     = REFS_W'(1);
                wr_dirty_en = 1'b1;
                wr_dirty    = 1'b0;
            end else begin
                n_res_status = STAT_FULL;
            end
        end else begin
            n_res_slot = r_sidx;
            if (!r_p_inr || r_p_refs == '0) begin
                n_res_status = STAT_FREE_PUT;
                n_res_dev    = r_p_inr ? r_p_dev : '0;
            end else begin
                n_res_dev   = r_p_dev;
                n_res_refs  = put_refs;
                wr_idx      = put_idx;
                wr_refs_en  = 1'b1;
                wr_refs     = put_refs;
                wr_dirty_en = 1'b1;
                wr_dirty    = put_dirty;
                if (put_refs == '0 && put_dirty) begin
                    // last reference on a dirty inode: write it back
                    wr_dirty  = 1'b0;
                    n_res_wb  = 1'b1;
                    n_res_blk = (r_p_pos >> OFFSET_W) + r_start_blk;
                    n_res_off = r_p_pos[OFFSET_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_ino[i]   <= '0;
                r_slot_dev[i]   <= '0;
                r_slot_refs[i]  <= '0;
                r_slot_dirty[i] <= 1'b0;
            end
        end else if (i_cmd.update) begin
            if (wr_claim) begin
                r_slot_ino[wr_idx] <= r_ino;
                r_slot_dev[wr_idx] <= r_dev;
            end
            if (wr_refs_en)  r_slot_refs[wr_idx]  <= wr_refs;
            if (wr_dirty_en) r_slot_dirty[wr_idx] <= wr_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res_slot   <= n_res_slot;
            r_res_status <= n_res_status;
            r_res_hit    <= n_res_hit;
            r_res_load   <= n_res_load;
            r_res_wb     <= n_res_wb;
            r_res_blk    <= n_res_blk;
            r_res_off    <= n_res_off;
            r_res_dev    <= n_res_dev;
            r_res_refs   <= n_res_refs;
        end
    end

    assign o_result_slot       = r_res_slot;
    assign o_status            = r_res_status;
    assign o_hit               = r_res_hit;
    assign o_load_request      = r_res_load;
    assign o_writeback_request = r_res_wb;
    assign o_disk_block        = r_res_blk;
    assign o_inode_offset      = r_res_off;
    assign o_slot_device       = r_res_dev;
    assign o_ref_count         = r_res_refs;

endmodule

@@ rtl/inode_slot_refcount_table.sv @@
// Flow: an accepted item is captured, searched, then updated; o_strobe rises with the results.
// A new item may be taken in the update cycle; busy is high only in the search cycle, set by the
//   register-slot tag compare and free-slot search that precede the count update.
// Reset (i_rst_n low, synchronous): all slots free with inode 0, device 0, clean; table start 0.
// Results are strobed for one cycle; the receiver cannot stall, so nothing is held back.
module inode_slot_refcount_table #(
    parameter int SLOT_COUNT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [31:0] i_inode_number,
    input  logic [7:0]  i_device_id,
    input  logic [5:0]  i_slot_index,
    input  logic        i_modified,
    // configuration: inode table start block
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    // result channel
    output logic        o_strobe,
    output logic [5:0]  o_result_slot,
    output logic [1:0]  o_status,
    output logic        o_hit,
    output logic        o_load_request,
    output logic        o_writeback_request,
    output logic [31:0] o_disk_block,
    output logic [2:0]  o_inode_offset,
    output logic [7:0]  o_slot_device,
    output logic [15:0] o_ref_count
);
    import isrt_pkg::*;

    `include "inode_slot_refcount_table_macros.svh"

    t_cmd cmd;
    logic req_any;

    // Sequencer: idle -> search -> update; a new item may be taken in the update cycle.
    isrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_cmd    (cmd),
        .o_strobe (o_strobe)
    );

    // Slots live in flip-flops so every tag is compared in parallel.
    isrt_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_operation         (i_operation),
        .i_inode_number      (i_inode_number),
        .i_device_id         (i_device_id),
        .i_slot_index        (i_slot_index),
        .i_modified          (i_modified),
        .o_result_slot       (o_result_slot),
        .o_status            (o_status),
        .o_hit               (o_hit),
        .o_load_request      (o_load_request),
        .o_writeback_request (o_writeback_request),
        .o_disk_block        (o_disk_block),
        .o_inode_offset      (o_inode_offset),
        .o_slot_device       (o_slot_device),
        .o_ref_count         (o_ref_count)
    );

    // any hit, load or write-back flag on the result ports
    assign req_any = o_hit | o_load_request | o_writeback_request;

    // every accepted item is followed by a strobe once its update cycle is over
    `ISRT_ASSERT_IMPL(a_item_result, start && !busy, ##3 o_strobe)
    // search occupies a single cycle
    `ISRT_ASSERT_NEXT(a_busy_one_cycle, busy, !busy)
    // an error result carries no hit, load or write-back
    `ISRT_ASSERT_IMPL(a_err_no_req, o_strobe && o_status != STAT_OK, !req_any)
    // a hit never requests a load or a write-back
    `ISRT_ASSERT_IMPL(a_hit_no_load, o_strobe && o_hit, !o_load_request && !o_writeback_request)

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the inode slot reference count table.
`timescale 1ns / 100ps

module testbench;
    import isrt_pkg::*;

    localparam int N_SLOTS     = 64;
    localparam int CYCLE_LIMIT = 2_000_000;  // cycle limit of the watchdog below

    // One result item as the block reports it.
    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot;
        logic [1:0]            status;
        logic                  hit;
        logic                  load;
        logic                  wb;
        logic [INO_W-1:0]      block;
        logic [OFFSET_W-1:0]   offset;
        logic [DEV_W-1:0]      dev;
        logic [REFS_W-1:0]     refs;
    } t_outcome;

    // One row of the directed table; typed rows carry a hand-written result.
    typedef struct {
        logic                  op;
        logic [INO_W-1:0]      ino;
        logic [DEV_W-1:0]      dev;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  mod;
        bit                    typed;
        t_outcome              want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_operation;
    logic [INO_W-1:0]      i_inode_number;
    logic [DEV_W-1:0]      i_device_id;
    logic [SLOT_IDX_W-1:0] i_slot_index;
    logic                  i_modified;
    logic                  i_cfg_wr_en;
    logic [31:0]           i_cfg_wr_data;
    logic                  o_strobe;
    logic [SLOT_IDX_W-1:0] o_result_slot;
    logic [1:0]            o_status;
    logic                  o_hit;
    logic                  o_load_request;
    logic                  o_writeback_request;
    logic [31:0]           o_disk_block;
    logic [OFFSET_W-1:0]   o_inode_offset;
    logic [DEV_W-1:0]      o_slot_device;
    logic [REFS_W-1:0]     o_ref_count;

    // Mirror of the slot table and the table start register.
    logic [INO_W-1:0]  tag_ino   [N_SLOTS];
    logic [DEV_W-1:0]  tag_dev   [N_SLOTS];
    logic [REFS_W-1:0] ref_cnt   [N_SLOTS];
    logic              dirty_bit [N_SLOTS];
    logic [31:0]       table_base;

    t_outcome pending_results[$];  // predicted results, oldest first
    t_row     dir_rows[$];
    int       fail_count;
    int       cycle_count;
    bit       gaps_on;

    inode_slot_refcount_table #(
        .SLOT_COUNT(N_SLOTS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_operation         (i_operation),
        .i_inode_number      (i_inode_number),
        .i_device_id         (i_device_id),
        .i_slot_index        (i_slot_index),
        .i_modified          (i_modified),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .o_strobe            (o_strobe),
        .o_result_slot       (o_result_slot),
        .o_status            (o_status),
        .o_hit               (o_hit),
        .o_load_request      (o_load_request),
        .o_writeback_request (o_writeback_request),
        .o_disk_block        (o_disk_block),
        .o_inode_offset      (o_inode_offset),
        .o_slot_device       (o_slot_device),
        .o_ref_count         (o_ref_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case results stop coming.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("inode_slot_refcount_table: mismatch");
        $finish;
    end

    function automatic t_outcome make_outcome(
        logic [SLOT_IDX_W-1:0] slot, logic [1:0] status, logic hit, logic load, logic wb,
        logic [INO_W-1:0] block, logic [OFFSET_W-1:0] offset, logic [DEV_W-1:0] dev,
        logic [REFS_W-1:0] refs);
        t_outcome r;
        r.slot   = slot;
        r.status = status;
        r.hit    = hit;
        r.load   = load;
        r.wb     = wb;
        r.block  = block;
        r.offset = offset;
        r.dev    = dev;
        r.refs   = refs;
        return r;
    endfunction

    // Disk position of an inode: 8 per block, counted from the table start.
    function automatic void locate_block(logic [INO_W-1:0] ino, inout t_outcome r);
        logic [INO_W-1:0] pos;
        pos      = ino - INO_W'(1);
        r.block  = (pos >> 3) + table_base;
        r.offset = pos[OFFSET_W-1:0];
    endfunction

    // Number of slots in the mirror with no references.
    function automatic int count_free();
        int n;
        n = 0;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (ref_cnt[i] == '0) n++;
        end
        return n;
    endfunction

    // Applies one accepted item to the mirror and returns the result it must produce.
    function automatic t_outcome predict_access(logic op, logic [INO_W-1:0] ino,
        logic [DEV_W-1:0] dev, logic [SLOT_IDX_W-1:0] slot, logic mod);
        t_outcome r;
        int       free_idx;
        r = '0;
        if (op == OP_GET) begin
            if (ino == '0) begin
                r.status = STAT_ZERO_INO;
                return r;
            end
            // Tag compare on inode only; a free slot still holding the tag is revived.
            for (int i = 0; i < N_SLOTS; i++) begin
                if (tag_ino[i] != '0 && tag_ino[i] == ino) begin
                    if (ref_cnt[i] != '1) ref_cnt[i] = ref_cnt[i] + REFS_W'(1);
                    r.slot = SLOT_IDX_W'(i);
                    r.hit  = 1'b1;
                    r.dev  = tag_dev[i];
                    r.refs = ref_cnt[i];
                    return r;
                end
            end
            free_idx = -1;
            for (int i = N_SLOTS - 1; i >= 0; i--) begin
                if (ref_cnt[i] == '0) free_idx = i;
            end
            if (free_idx < 0) begin
                r.status = STAT_FULL;
                return r;
            end
            tag_ino[free_idx]   = ino;
            tag_dev[free_idx]   = dev;
            ref_cnt[free_idx]   = REFS_W'(1);
            dirty_bit[free_idx] = 1'b0;
            r.slot = SLOT_IDX_W'(free_idx);
            r.load = 1'b1;
            locate_block(ino, r);
            r.dev  = dev;
            r.refs = REFS_W'(1);
        end else begin
            r.slot = slot;
            if (ref_cnt[slot] == '0) begin
                r.status = STAT_FREE_PUT;
                r.dev    = tag_dev[slot];
                return r;
            end
            if (mod) dirty_bit[slot] = 1'b1;
            ref_cnt[slot] = ref_cnt[slot] - REFS_W'(1);
            r.dev  = tag_dev[slot];
            r.refs = ref_cnt[slot];
            if (ref_cnt[slot] == '0 && dirty_bit[slot]) begin
                dirty_bit[slot] = 1'b0;
                r.wb = 1'b1;
                locate_block(tag_ino[slot], r);
            end
        end
        return r;
    endfunction

    function automatic void add_row(logic op, logic [INO_W-1:0] ino, logic [DEV_W-1:0] dev,
        logic [SLOT_IDX_W-1:0] slot, logic mod, bit typed, t_outcome want);
        t_row row;
        row.op    = op;
        row.ino   = ino;
        row.dev   = dev;
        row.slot  = slot;
        row.mod   = mod;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // Presents one item, holds it until accepted, then logs its predicted result.
    task automatic send_item(logic op, logic [INO_W-1:0] ino, logic [DEV_W-1:0] dev,
        logic [SLOT_IDX_W-1:0] slot, logic mod, bit typed, t_outcome want);
        int       gap;
        t_outcome predicted;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_operation    <= op;
        i_inode_number <= ino;
        i_device_id    <= dev;
        i_slot_index   <= slot;
        i_modified     <= mod;
        do @(posedge i_clk); while (busy);
        predicted = predict_access(op, ino, dev, slot, mod);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drops start and waits for every outstanding result, plus the pipeline depth.
    task automatic settle;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called while settled, so no item sees a half-updated base.
    task automatic write_table_base(logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        table_base = value;
    endtask

    // Well-formed traffic mostly: gets from a small inode pool so hits and
    // revivals happen, puts on slots that are held. The rest is noise.
    task automatic random_item(int get_pct);
        int               pick;
        int               held[$];
        logic [INO_W-1:0] ino;
        logic [SLOT_IDX_W-1:0] slot;
        pick = $urandom_range(0, 99);
        ino  = $urandom;
        slot = SLOT_IDX_W'($urandom_range(0, N_SLOTS - 1));
        if (pick < get_pct) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)      ino = $urandom_range(1, 96);
            else if (pick < 85) ino = $urandom_range(32'hFFFF_FF00, 32'hFFFF_FFFF);
            else if (pick < 96) ino = $urandom;
            else                ino = '0;
            send_item(OP_GET, ino, DEV_W'($urandom_range(0, 255)), slot,
                      1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
            for (int i = 0; i < N_SLOTS; i++) begin
                if (ref_cnt[i] != '0) held.push_back(i);
            end
            if (held.size() != 0 && $urandom_range(0, 99) < 80)
                slot = SLOT_IDX_W'(held[$urandom_range(0, held.size() - 1)]);
            send_item(OP_PUT, ino, DEV_W'($urandom_range(0, 255)), slot,
                      1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result monitor: every strobe must match the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result_slot: expected no result, got %0h", o_result_slot);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_slot", want.slot, o_result_slot);
                check_field("status", want.status, o_status);
                check_field("hit", want.hit, o_hit);
                check_field("load_request", want.load, o_load_request);
                check_field("writeback_request", want.wb, o_writeback_request);
                check_field("disk_block", want.block, o_disk_block);
                check_field("inode_offset", want.offset, o_inode_offset);
                check_field("slot_device", want.dev, o_slot_device);
                check_field("ref_count", want.refs, o_ref_count);
            end
        end
    end

    initial begin : stimulus
        logic [31:0] bases [5];
        int          get_pct [5];
        int          k;
        fail_count     = 0;
        gaps_on        = 1'b0;
        table_base     = '0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = OP_GET;
        i_inode_number = '0;
        i_device_id    = '0;
        i_slot_index   = '0;
        i_modified     = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            tag_ino[i]   = '0;
            tag_dev[i]   = '0;
            ref_cnt[i]   = '0;
            dirty_bit[i] = 1'b0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table, table start still at its reset value of 0.
        // zero inode number is rejected outright
        add_row(OP_GET, 32'h0, 8'hAA, 6'd0, 1'b0, 1,
                make_outcome(0, STAT_ZERO_INO, 0, 0, 0, 0, 0, 0, 0));
        // put on a slot never used
        add_row(OP_PUT, 32'h0, 8'h00, 6'd5, 1'b1, 1,
                make_outcome(5, STAT_FREE_PUT, 0, 0, 0, 0, 0, 0, 0));
        // first miss claims slot 0, lowest inode
        add_row(OP_GET, 32'h1, 8'hFF, 6'd0, 1'b0, 1,
                make_outcome(0, STAT_OK, 0, 1, 0, 0, 0, 8'hFF, 1));
        // highest inode: block (2^32-2)/8, offset 6
        add_row(OP_GET, 32'hFFFF_FFFF, 8'h00, 6'd0, 1'b0, 1,
                make_outcome(1, STAT_OK, 0, 1, 0, 32'h1FFF_FFFF, 6, 8'h00, 1));
        // hit keeps the stored device
        add_row(OP_GET, 32'h1, 8'h12, 6'd0, 1'b0, 1,
                make_outcome(0, STAT_OK, 1, 0, 0, 0, 0, 8'hFF, 2));
        // dirty mark recorded while references remain
        add_row(OP_PUT, 32'h0, 8'h00, 6'd0, 1'b1, 1,
                make_outcome(0, STAT_OK, 0, 0, 0, 0, 0, 8'hFF, 1));
        // last reference on a dirty slot asks for write-back
        add_row(OP_PUT, 32'h0, 8'h00, 6'd0, 1'b0, 1,
                make_outcome(0, STAT_OK, 0, 0, 1, 0, 0, 8'hFF, 0));
        // free slot still holding the tag comes back as a hit
        add_row(OP_GET, 32'h1, 8'h34, 6'd0, 1'b0, 1,
                make_outcome(0, STAT_OK, 1, 0, 0, 0, 0, 8'hFF, 1));
        // clean drop to zero: no write-back
        add_row(OP_PUT, 32'h0, 8'h00, 6'd0, 1'b0, 1,
                make_outcome(0, STAT_OK, 0, 0, 0, 0, 0, 8'hFF, 0));
        // put on a free slot ignores modified and reports its device
        add_row(OP_PUT, 32'h0, 8'h00, 6'd0, 1'b1, 1,
                make_outcome(0, STAT_FREE_PUT, 0, 0, 0, 0, 0, 8'hFF, 0));
        add_row(OP_GET, 32'h1, 8'h56, 6'd0, 1'b0, 0, '0);
        add_row(OP_PUT, 32'h0, 8'h00, 6'd0, 1'b0, 0, '0);
        add_row(OP_PUT, 32'hFFFF_FFFF, 8'hFF, 6'd63, 1'b1, 1,
                make_outcome(63, STAT_FREE_PUT, 0, 0, 0, 0, 0, 0, 0));
        // write-back of the top inode
        add_row(OP_PUT, 32'h0, 8'h00, 6'd1, 1'b1, 1,
                make_outcome(1, STAT_OK, 0, 0, 1, 32'h1FFF_FFFF, 6, 8'h00, 0));
        // misses now reuse freed slots, evicting the old tags
        add_row(OP_GET, 32'h9, 8'h55, 6'd0, 1'b0, 0, '0);
        add_row(OP_GET, 32'h8, 8'hA5, 6'd0, 1'b0, 0, '0);
        add_row(OP_GET, 32'h1, 8'h01, 6'd0, 1'b0, 0, '0);
        add_row(OP_GET, 32'h8000_0000, 8'h80, 6'd0, 1'b0, 0, '0);
        add_row(OP_PUT, 32'h0, 8'h00, 6'd42, 1'b1, 0, '0);
        add_row(OP_PUT, 32'h0, 8'h00, 6'd3, 1'b1, 0, '0);

        gaps_on = 1'b1;
        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].ino, dir_rows[i].dev, dir_rows[i].slot,
                      dir_rows[i].mod, dir_rows[i].typed, dir_rows[i].want);

        // Fill every slot, then two misses that must report a full table,
        // and a hit that must still work while full.
        k = 0;
        while (count_free() != 0) begin
            send_item(OP_GET, 32'd5000 + k, k[7:0], 6'd0, 1'b0, 0, '0);
            k++;
        end
        send_item(OP_GET, 32'd9000, 8'h11, 6'd0, 1'b0, 1,
                  make_outcome(0, STAT_FULL, 0, 0, 0, 0, 0, 0, 0));
        send_item(OP_GET, 32'hFFFF_FFFE, 8'h22, 6'd0, 1'b0, 1,
                  make_outcome(0, STAT_FULL, 0, 0, 0, 0, 0, 0, 0));
        send_item(OP_GET, 32'h9, 8'h00, 6'd0, 1'b0, 0, '0);

        // Release everything; a mix of dirty and clean drops.
        for (int s = 0; s < N_SLOTS; s++) begin
            while (ref_cnt[s] != '0)
                send_item(OP_PUT, 32'h0, 8'h00, SLOT_IDX_W'(s), 1'($urandom_range(0, 1)),
                          0, '0);
        end

        // Random phases, each with its own table start; config written only
        // while settled. Phase mix swings between filling and draining.
        bases[0]   = 32'hFFFF_FFFF;
        bases[1]   = $urandom;
        bases[2]   = 32'h0;
        bases[3]   = 32'h8000_0000;
        bases[4]   = $urandom;
        get_pct[0] = 70;
        get_pct[1] = 45;
        get_pct[2] = 62;
        get_pct[3] = 40;
        get_pct[4] = 55;
        for (int p = 0; p < 5; p++) begin
            settle();
            write_table_base(bases[p]);
            gaps_on = (p != 4);  // final stretch runs back to back
            for (int n = 0; n < 70; n++) random_item(get_pct[p]);
            // mid-phase pause until the table has answered everything
            settle();
            for (int n = 0; n < 70; n++) random_item(get_pct[p]);
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("inode_slot_refcount_table: match");
        end else begin
            $display("inode_slot_refcount_table: mismatch");
        end
        $finish;
    end

endmodule

@@ inode_slot_refcount_table.f @@
+incdir+rtl
rtl/isrt_pkg.sv
rtl/isrt_ctrl.sv
rtl/isrt_dp.sv
rtl/inode_slot_refcount_table.sv
bench/testbench.sv
